// ===== sv/ppcr_pkg.sv =====
// ----------------------------------------------------------------------------
// ppcr_pkg
// Shared types and constants of the point/plane collision response pipeline.
// ----------------------------------------------------------------------------
package ppcr_pkg;

    localparam int unsigned COORD_W    = 32;
    localparam int unsigned FRIC_W     = 17;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned DIF_W      = 33;   // difference of two coordinates
    localparam int unsigned PROD_W     = 65;   // difference times normal
    localparam int unsigned SUM_W      = 67;   // exact side value
    localparam int unsigned MAG_W      = 33;   // |cur - prev| and |correction|
    localparam int unsigned RATIO_BITS = 30;
    localparam int unsigned T_W        = RATIO_BITS + 1;
    localparam int unsigned RR_W       = 31;
    localparam int unsigned SQ_W       = 64;
    localparam int unsigned ROOT_W     = 32;

    localparam logic [FRIC_W-1:0]  FRIC_ONE       = 17'd65536;
    localparam logic [COORD_W-1:0] NORMAL_Y_RESET = 32'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PLANE_X  = 3'd0,
        REG_PLANE_Y  = 3'd1,
        REG_PLANE_Z  = 3'd2,
        REG_NORMAL_X = 3'd3,
        REG_NORMAL_Y = 3'd4,
        REG_NORMAL_Z = 3'd5,
        REG_FRICTION = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] prev_x;
        logic signed [COORD_W-1:0] prev_y;
        logic signed [COORD_W-1:0] prev_z;
        logic signed [COORD_W-1:0] cur_x;
        logic signed [COORD_W-1:0] cur_y;
        logic signed [COORD_W-1:0] cur_z;
    } pt_word_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic                      crossed;
    } res_word_t;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] plane;
        logic [2:0][COORD_W-1:0] normal;
        logic [FRIC_W-1:0]       friction;
    } cfg_t;

    // data that rides along with every word through the pipeline
    typedef struct packed {
        logic [2:0][COORD_W-1:0] prev;
        logic [2:0][COORD_W-1:0] cur;
        logic [2:0][MAG_W-1:0]   dmag;
        logic [2:0]              dneg;
        logic                    crossed;
    } pass_t;

    typedef struct packed {
        logic [2:0][MAG_W-1:0] cm;
        logic [2:0][RR_W-1:0]  rr;
    } corr_t;

    function automatic logic signed [DIF_W-1:0] sdiff(input logic [COORD_W-1:0] a,
                                                      input logic [COORD_W-1:0] b);
        return $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    endfunction

endpackage

// ===== sv/ppcr_side.sv =====
// ----------------------------------------------------------------------------
// ppcr_side
// Exact side values of both positions, floor to integer units, and the
// numerator and denominator of the crossing ratio. Five stages.
// ----------------------------------------------------------------------------
module ppcr_side
    import ppcr_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    localparam int FW = SUM_W - FRAC_BITS,
    localparam int UW = FW + 1
)(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  pt_word_t      in_word,
    input  cfg_t          cfg,
    output logic          out_valid,
    output pass_t         out_pass,
    output logic [UW-1:0] un,
    output logic [UW-1:0] ud,
    output logic          ud_zero
);

    logic [4:0] v_reg;
    pass_t p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    pass_t p1_next, p2_next, p4_next;

    logic signed [DIF_W-1:0]  pd1_reg [3], cd1_reg [3], dd1_reg [3];
    logic signed [DIF_W-1:0]  pd1_next [3], cd1_next [3], dd1_next [3];
    logic signed [PROD_W-1:0] pp2_reg [3], pc2_reg [3];
    logic signed [PROD_W-1:0] pp2_next [3], pc2_next [3];
    logic signed [SUM_W-1:0]  sp3_reg, sc3_reg, sp3_next, sc3_next;
    logic signed [FW-1:0]     fp, fc;
    logic signed [UW-1:0]     fpx, dif4_reg, dif4_next;
    logic [UW-1:0]            un4_reg, un4_next, un5_reg, ud5_reg, ud5_next;
    logic                     udz5_reg, pos_p, pos_c;

    always_comb
    begin
        p1_next      = '0;
        p1_next.prev = {in_word.prev_z, in_word.prev_y, in_word.prev_x};
        p1_next.cur  = {in_word.cur_z, in_word.cur_y, in_word.cur_x};
        for (int k = 0; k < 3; k++)
        begin
            pd1_next[k] = sdiff(p1_next.prev[k], cfg.plane[k]);
            cd1_next[k] = sdiff(p1_next.cur[k], cfg.plane[k]);
            dd1_next[k] = sdiff(p1_next.cur[k], p1_next.prev[k]);
        end

        p2_next = p1_reg;
        for (int k = 0; k < 3; k++)
        begin
            pp2_next[k] = PROD_W'(pd1_reg[k]) * PROD_W'($signed(cfg.normal[k]));
            pc2_next[k] = PROD_W'(cd1_reg[k]) * PROD_W'($signed(cfg.normal[k]));
            p2_next.dmag[k] = dd1_reg[k][DIF_W-1] ? $unsigned(-dd1_reg[k])
                                                  : $unsigned(dd1_reg[k]);
            p2_next.dneg[k] = dd1_reg[k][DIF_W-1];
        end

        sp3_next = SUM_W'(pp2_reg[0]) + SUM_W'(pp2_reg[1]) + SUM_W'(pp2_reg[2]);
        sc3_next = SUM_W'(pc2_reg[0]) + SUM_W'(pc2_reg[1]) + SUM_W'(pc2_reg[2]);

        // dropping the fraction bits of a two's complement value floors it
        fp    = $signed(sp3_reg[SUM_W-1:FRAC_BITS]);
        fc    = $signed(sc3_reg[SUM_W-1:FRAC_BITS]);
        pos_p = !sp3_reg[SUM_W-1] && (sp3_reg != '0);
        pos_c = !sc3_reg[SUM_W-1] && (sc3_reg != '0);
        p4_next = p3_reg;
        p4_next.crossed = pos_p != pos_c;
        fpx       = $signed({fp[FW-1], fp});
        un4_next  = fpx[UW-1] ? $unsigned(-fpx) : $unsigned(fpx);
        dif4_next = $signed({fc[FW-1], fc}) - fpx;

        ud5_next = dif4_reg[UW-1] ? $unsigned(-dif4_reg) : $unsigned(dif4_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg   <= p1_next;
            pd1_reg  <= pd1_next;
            cd1_reg  <= cd1_next;
            dd1_reg  <= dd1_next;
            p2_reg   <= p2_next;
            pp2_reg  <= pp2_next;
            pc2_reg  <= pc2_next;
            p3_reg   <= p2_reg;
            sp3_reg  <= sp3_next;
            sc3_reg  <= sc3_next;
            p4_reg   <= p4_next;
            un4_reg  <= un4_next;
            dif4_reg <= dif4_next;
            p5_reg   <= p4_reg;
            un5_reg  <= un4_reg;
            ud5_reg  <= ud5_next;
            udz5_reg <= dif4_reg == '0;
        end
    end

    assign out_valid = v_reg[4];
    assign out_pass  = p5_reg;
    assign un        = un5_reg;
    assign ud        = ud5_reg;
    assign ud_zero   = udz5_reg;

endmodule

// ===== sv/ppcr_div.sv =====
// ----------------------------------------------------------------------------
// ppcr_div
// Pipelined restoring divider for the crossing ratio, one quotient bit per
// stage: t = floor(un * 2^30 / ud), forced to zero when ud is zero.
// ----------------------------------------------------------------------------
module ppcr_div
    import ppcr_pkg::*;
#(
    parameter int UW = 52
)(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  pass_t          in_pass,
    input  logic [UW-1:0]  un,
    input  logic [UW-1:0]  ud,
    input  logic           ud_zero,
    output logic           out_valid,
    output pass_t          out_pass,
    output logic [T_W-1:0] t
);

    localparam int NS = T_W;

    logic [NS-1:0]  v_reg, udz_reg, take;
    pass_t          pass_reg [NS];
    logic [UW-1:0]  rem_reg [NS], ud_reg [NS], rem_next [NS], dv [NS];
    logic [T_W-1:0] q_reg [NS], q_next [NS], qv [NS];
    logic [UW:0]    a [NS];

    always_comb
    begin
        for (int j = 0; j < NS; j++)
        begin
            if (j == 0)
            begin
                a[j]  = {1'b0, un};
                dv[j] = ud;
                qv[j] = '0;
            end
            else
            begin
                a[j]  = {rem_reg[j-1], 1'b0};
                dv[j] = ud_reg[j-1];
                qv[j] = q_reg[j-1];
            end
            take[j]     = a[j] >= {1'b0, dv[j]};
            rem_next[j] = take[j] ? UW'(a[j] - {1'b0, dv[j]}) : a[j][UW-1:0];
            q_next[j]   = {qv[j][T_W-2:0], take[j]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < NS; j++)
            begin
                rem_reg[j] <= rem_next[j];
                q_reg[j]   <= q_next[j];
                ud_reg[j]  <= dv[j];
                if (j == 0)
                begin
                    pass_reg[j] <= in_pass;
                    udz_reg[j]  <= ud_zero;
                end
                else
                begin
                    pass_reg[j] <= pass_reg[j-1];
                    udz_reg[j]  <= udz_reg[j-1];
                end
            end
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_pass  = pass_reg[NS-1];
    assign t         = udz_reg[NS-1] ? '0 : q_reg[NS-1];

endmodule

// ===== sv/ppcr_norm.sv =====
// ----------------------------------------------------------------------------
// ppcr_norm
// Correction vector from the ratio, prescale to 31 bits, and sum of squares
// for the length. Five stages.
// ----------------------------------------------------------------------------
module ppcr_norm
    import ppcr_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  pass_t           in_pass,
    input  logic [T_W-1:0]  t,
    output logic            out_valid,
    output pass_t           out_pass,
    output corr_t           out_corr,
    output logic [SQ_W-1:0] sum
);

    localparam logic [63:0] RND = 64'd1 << (RATIO_BITS - 1);

    logic [4:0] v_reg;
    pass_t p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic [63:0]         prod1_reg [3], rnd [3];
    logic [MAG_W-1:0]    cm2_reg [3], cm3_reg [3], cm4_reg [3], cm5_reg [3];
    logic [RR_W-1:0]     rr3_reg [3], rr4_reg [3], rr5_reg [3], rr_next [3];
    logic [2*RR_W-1:0]   sq4_reg [3];
    logic [SQ_W-1:0]     sum5_reg;
    logic                sh2, sh1;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            rnd[k] = prod1_reg[k] + RND;
        end
        // smallest shift that brings every component below 2^31
        sh2 = cm2_reg[0][MAG_W-1] | cm2_reg[1][MAG_W-1] | cm2_reg[2][MAG_W-1];
        sh1 = cm2_reg[0][MAG_W-2] | cm2_reg[1][MAG_W-2] | cm2_reg[2][MAG_W-2];
        for (int k = 0; k < 3; k++)
        begin
            if (sh2)
            begin
                rr_next[k] = cm2_reg[k][MAG_W-1:2];
            end
            else if (sh1)
            begin
                rr_next[k] = cm2_reg[k][MAG_W-2:1];
            end
            else
            begin
                rr_next[k] = cm2_reg[k][RR_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg <= in_pass;
            p2_reg <= p1_reg;
            p3_reg <= p2_reg;
            p4_reg <= p3_reg;
            p5_reg <= p4_reg;
            for (int k = 0; k < 3; k++)
            begin
                prod1_reg[k] <= 64'(in_pass.dmag[k]) * 64'(t);
                cm2_reg[k]   <= rnd[k][RATIO_BITS+MAG_W-1:RATIO_BITS];
                cm3_reg[k]   <= cm2_reg[k];
                rr3_reg[k]   <= rr_next[k];
                cm4_reg[k]   <= cm3_reg[k];
                rr4_reg[k]   <= rr3_reg[k];
                sq4_reg[k]   <= (2*RR_W)'(rr3_reg[k]) * (2*RR_W)'(rr3_reg[k]);
                cm5_reg[k]   <= cm4_reg[k];
                rr5_reg[k]   <= rr4_reg[k];
            end
            sum5_reg <= SQ_W'(sq4_reg[0]) + SQ_W'(sq4_reg[1]) + SQ_W'(sq4_reg[2]);
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            out_corr.cm[k] = cm5_reg[k];
            out_corr.rr[k] = rr5_reg[k];
        end
    end

    assign out_valid = v_reg[4];
    assign out_pass  = p5_reg;
    assign sum       = sum5_reg;

endmodule

// ===== sv/ppcr_sqrt.sv =====
// ----------------------------------------------------------------------------
// ppcr_sqrt
// Pipelined integer square root, one root bit per stage, 32 stages.
// ----------------------------------------------------------------------------
module ppcr_sqrt
    import ppcr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  pass_t             in_pass,
    input  corr_t             in_corr,
    input  logic [SQ_W-1:0]   sum,
    output logic              out_valid,
    output pass_t             out_pass,
    output corr_t             out_corr,
    output logic [ROOT_W-1:0] root
);

    localparam int NS = ROOT_W;
    localparam int TW = SQ_W + 2;

    logic [NS-1:0]     v_reg, take;
    pass_t             pass_reg [NS];
    corr_t             corr_reg [NS];
    logic [SQ_W-1:0]   rem_reg [NS], rem_next [NS], rin [NS];
    logic [ROOT_W-1:0] root_reg [NS], root_next [NS], rtin [NS];
    logic [TW-1:0]     term [NS];

    always_comb
    begin
        for (int j = 0; j < NS; j++)
        begin
            if (j == 0)
            begin
                rin[j]  = sum;
                rtin[j] = '0;
            end
            else
            begin
                rin[j]  = rem_reg[j-1];
                rtin[j] = root_reg[j-1];
            end
            // (root + 2^i)^2 - root^2, with i the bit tried in this stage
            term[j] = (TW'(rtin[j]) << (NS - j)) + (TW'(1) << (2 * (NS - 1 - j)));
            take[j] = TW'(rin[j]) >= term[j];
            rem_next[j]  = take[j] ? SQ_W'(TW'(rin[j]) - term[j]) : rin[j];
            root_next[j] = take[j] ? (rtin[j] | (ROOT_W'(1) << (NS - 1 - j))) : rtin[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < NS; j++)
            begin
                rem_reg[j]  <= rem_next[j];
                root_reg[j] <= root_next[j];
                if (j == 0)
                begin
                    pass_reg[j] <= in_pass;
                    corr_reg[j] <= in_corr;
                end
                else
                begin
                    pass_reg[j] <= pass_reg[j-1];
                    corr_reg[j] <= corr_reg[j-1];
                end
            end
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_pass  = pass_reg[NS-1];
    assign out_corr  = corr_reg[NS-1];
    assign root      = root_reg[NS-1];

endmodule

// ===== sv/ppcr_resp.sv =====
// ----------------------------------------------------------------------------
// ppcr_resp
// Surface offset along the correction (short pipelined divide by the
// length), friction scaling, saturation and final position select.
// ----------------------------------------------------------------------------
module ppcr_resp
    import ppcr_pkg::*;
#(
    parameter int OFFSET_LSB = 7
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  pass_t             in_pass,
    input  corr_t             in_corr,
    input  logic [ROOT_W-1:0] root,
    input  logic [FRIC_W-1:0] gain,
    output logic              out_valid,
    output res_word_t         out_word
);

    localparam int K2   = 2 * OFFSET_LSB;
    localparam int KW   = $clog2(K2 + 2);
    localparam int NW   = RR_W + KW + 1;
    localparam int QB   = $clog2(OFFSET_LSB + 2);
    localparam int DW   = ROOT_W + 1;
    localparam int RW   = NW + QB + DW;
    localparam int E_W  = MAG_W + 1;
    localparam int FP_W = MAG_W + FRIC_W;
    localparam int SM_W = FP_W - 16;
    localparam int ST_W = SM_W + 1;
    localparam int OS_W = COORD_W + 4;
    localparam int NSTG = QB + 6;
    localparam logic [NW-1:0] K2_C = NW'(K2);
    localparam logic [FP_W-1:0] HALF = FP_W'(32768);

    logic [NSTG-1:0] v_reg;

    // offset numerator and denominator
    pass_t           p0_reg;
    corr_t           c0_reg;
    logic [NW-1:0]   num0_reg [3];
    logic [DW-1:0]   den0_reg;
    logic            mz0_reg;

    // divide stages
    pass_t           pq_reg [QB];
    corr_t           cq_reg [QB];
    logic [NW-1:0]   qrem_reg [QB][3], qrem_next [QB][3], qrin [QB][3];
    logic [QB-1:0]   qq_reg [QB][3], qq_next [QB][3], qqin [QB][3];
    logic [DW-1:0]   qden_reg [QB], qdin [QB];
    logic [QB-1:0]   qmz_reg;
    logic [RW-1:0]   dsh [QB];
    logic            qtake [QB][3];

    // friction stages
    pass_t                  p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [E_W-1:0]  e1_reg [3];
    logic [2:0]             s1_reg, aneg2_reg, aneg3_reg;
    logic [MAG_W-1:0]       amag2_reg [3];
    logic [FP_W-1:0]        prod3_reg [3], rnd3 [3];
    logic signed [ST_W-1:0] step4_reg [3];
    logic [QB-1:0]          om [3];
    logic signed [OS_W-1:0] osum [3];
    logic [COORD_W-1:0]     osat [3], opick [3];
    res_word_t              word5_reg;

    always_comb
    begin
        for (int j = 0; j < QB; j++)
        begin
            if (j == 0)
            begin
                qdin[j] = den0_reg;
            end
            else
            begin
                qdin[j] = qden_reg[j-1];
            end
            dsh[j] = RW'(qdin[j]) << (QB - 1 - j);
            for (int k = 0; k < 3; k++)
            begin
                if (j == 0)
                begin
                    qrin[j][k] = num0_reg[k];
                    qqin[j][k] = '0;
                end
                else
                begin
                    qrin[j][k] = qrem_reg[j-1][k];
                    qqin[j][k] = qq_reg[j-1][k];
                end
                qtake[j][k]     = RW'(qrin[j][k]) >= dsh[j];
                qrem_next[j][k] = qtake[j][k] ? NW'(RW'(qrin[j][k]) - dsh[j]) : qrin[j][k];
                qq_next[j][k]   = (qqin[j][k] << 1) | QB'(qtake[j][k]);
            end
        end

        for (int k = 0; k < 3; k++)
        begin
            // zero-length correction takes no offset
            om[k]   = qmz_reg[QB-1] ? '0 : qq_reg[QB-1][k];
            rnd3[k] = prod3_reg[k] + HALF;
            osum[k] = $signed(OS_W'($signed(p4_reg.prev[k]))) + OS_W'(step4_reg[k]);
            if (osum[k][OS_W-1:COORD_W-1] == '0 || osum[k][OS_W-1:COORD_W-1] == '1)
            begin
                osat[k] = osum[k][COORD_W-1:0];
            end
            else if (osum[k][OS_W-1])
            begin
                osat[k] = {1'b1, {(COORD_W-1){1'b0}}};
            end
            else
            begin
                osat[k] = {1'b0, {(COORD_W-1){1'b1}}};
            end
            opick[k] = p4_reg.crossed ? osat[k] : p4_reg.cur[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NSTG-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg   <= in_pass;
            c0_reg   <= in_corr;
            den0_reg <= {root, 1'b0};
            mz0_reg  <= root == '0;
            for (int k = 0; k < 3; k++)
            begin
                num0_reg[k] <= NW'(in_corr.rr[k]) * K2_C + NW'(root);
            end

            for (int j = 0; j < QB; j++)
            begin
                qden_reg[j] <= qdin[j];
                for (int k = 0; k < 3; k++)
                begin
                    qrem_reg[j][k] <= qrem_next[j][k];
                    qq_reg[j][k]   <= qq_next[j][k];
                end
                if (j == 0)
                begin
                    pq_reg[j]  <= p0_reg;
                    cq_reg[j]  <= c0_reg;
                    qmz_reg[j] <= mz0_reg;
                end
                else
                begin
                    pq_reg[j]  <= pq_reg[j-1];
                    cq_reg[j]  <= cq_reg[j-1];
                    qmz_reg[j] <= qmz_reg[j-1];
                end
            end

            p1_reg <= pq_reg[QB-1];
            p2_reg <= p1_reg;
            p3_reg <= p2_reg;
            p4_reg <= p3_reg;
            for (int k = 0; k < 3; k++)
            begin
                // offset shares the sign of the correction, so work on magnitudes
                e1_reg[k]    <= $signed(E_W'(cq_reg[QB-1].cm[k])) - $signed(E_W'(om[k]));
                s1_reg[k]    <= pq_reg[QB-1].dneg[k] && (cq_reg[QB-1].cm[k] != '0);
                amag2_reg[k] <= e1_reg[k][E_W-1] ? MAG_W'($unsigned(-e1_reg[k]))
                                                 : MAG_W'($unsigned(e1_reg[k]));
                aneg2_reg[k] <= s1_reg[k] ^ e1_reg[k][E_W-1];
                prod3_reg[k] <= FP_W'(amag2_reg[k]) * FP_W'(gain);
                aneg3_reg[k] <= aneg2_reg[k];
                step4_reg[k] <= aneg3_reg[k] ? -$signed({1'b0, rnd3[k][FP_W-1:16]})
                                             : $signed({1'b0, rnd3[k][FP_W-1:16]});
            end

            word5_reg.out_x   <= opick[0];
            word5_reg.out_y   <= opick[1];
            word5_reg.out_z   <= opick[2];
            word5_reg.crossed <= p4_reg.crossed;
        end
    end

    assign out_valid = v_reg[NSTG-1];
    assign out_word  = word5_reg;

endmodule

// ===== sv/point_plane_collision_response_top.sv =====
// ----------------------------------------------------------------------------
// point_plane_collision_response_top
// Point-mass / plane collision response: crossing test, pull-back to the
// crossing point with a surface offset, friction, saturation.
//
//   port group   dir   handshake            word
//   pt_*         in    pt_valid / pt_stall   pt_word_t  (prev and cur position)
//   res_*        out   res_valid / res_stall res_word_t (position, crossed)
//   cfg_*        in    cfg_we                cfg_index, cfg_data
//
// one word per clock while pt_stall is low; the pipeline includes the 31-stage
// ratio divider and the 32-stage square root
// reset clears valid bits and loads the register defaults; no clearing pass
// a held res_stall fills the skid register, and pt_stall rises the next cycle
// ----------------------------------------------------------------------------
module point_plane_collision_response_top
    import ppcr_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int OFFSET_LSB = 7
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pt_valid,
    output logic                 pt_stall,
    input  pt_word_t             pt_word,
    output logic                 res_valid,
    input  logic                 res_stall,
    output res_word_t            res_word,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_data
);

    localparam int UW = SUM_W - FRAC_BITS + 1;

    cfg_t              cfg_reg;
    logic [FRIC_W-1:0] gain;
    logic              en, out_free;

    logic              sd_valid, dv_valid, nm_valid, sq_valid, rp_valid;
    pass_t             sd_pass, dv_pass, nm_pass, sq_pass;
    corr_t             nm_corr, sq_corr;
    logic [UW-1:0]     un, ud;
    logic              ud_zero;
    logic [T_W-1:0]    t;
    logic [SQ_W-1:0]   sum;
    logic [ROOT_W-1:0] root;
    res_word_t         rp_word;

    logic              res_valid_reg, skid_valid_reg;
    res_word_t         res_word_reg, skid_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.plane    <= '0;
            cfg_reg.normal   <= {COORD_W'(0), NORMAL_Y_RESET, COORD_W'(0)};
            cfg_reg.friction <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PLANE_X:  cfg_reg.plane[0]  <= cfg_data;
                REG_PLANE_Y:  cfg_reg.plane[1]  <= cfg_data;
                REG_PLANE_Z:  cfg_reg.plane[2]  <= cfg_data;
                REG_NORMAL_X: cfg_reg.normal[0] <= cfg_data;
                REG_NORMAL_Y: cfg_reg.normal[1] <= cfg_data;
                REG_NORMAL_Z: cfg_reg.normal[2] <= cfg_data;
                REG_FRICTION: cfg_reg.friction  <= cfg_data[FRIC_W-1:0];
                default:      ;
            endcase
        end
    end

    // friction above one acts as one
    assign gain = FRIC_ONE - ((cfg_reg.friction > FRIC_ONE) ? FRIC_ONE : cfg_reg.friction);

    assign en       = !skid_valid_reg;
    assign pt_stall = skid_valid_reg;
    assign out_free = !res_valid_reg || !res_stall;

    ppcr_side #(.FRAC_BITS(FRAC_BITS)) u_side (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(pt_valid), .in_word(pt_word), .cfg(cfg_reg),
        .out_valid(sd_valid), .out_pass(sd_pass),
        .un(un), .ud(ud), .ud_zero(ud_zero)
    );

    ppcr_div #(.UW(UW)) u_div (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(sd_valid), .in_pass(sd_pass),
        .un(un), .ud(ud), .ud_zero(ud_zero),
        .out_valid(dv_valid), .out_pass(dv_pass), .t(t)
    );

    ppcr_norm u_norm (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(dv_valid), .in_pass(dv_pass), .t(t),
        .out_valid(nm_valid), .out_pass(nm_pass), .out_corr(nm_corr), .sum(sum)
    );

    ppcr_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(nm_valid), .in_pass(nm_pass), .in_corr(nm_corr), .sum(sum),
        .out_valid(sq_valid), .out_pass(sq_pass), .out_corr(sq_corr), .root(root)
    );

    ppcr_resp #(.OFFSET_LSB(OFFSET_LSB)) u_resp (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(sq_valid), .in_pass(sq_pass), .in_corr(sq_corr),
        .root(root), .gain(gain),
        .out_valid(rp_valid), .out_word(rp_word)
    );

    // output register with a skid word behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            res_valid_reg  <= skid_valid_reg || rp_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (!skid_valid_reg && rp_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            res_word_reg <= skid_valid_reg ? skid_word_reg : rp_word;
        end
        else if (!skid_valid_reg)
        begin
            skid_word_reg <= rp_word;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

endmodule
